### rtl/qdsk_pkg.sv
package qdsk_pkg;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_STEP_RPM  = 2'd1,
    REG_MIN_RPM   = 2'd2,
    REG_MAX_RPM   = 2'd3
  } reg_index_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;
  localparam logic signed [15:0] COUNT_MIN = -16'sh8000;
  localparam logic signed [4:0]  SUB_UP    = 5'sd4;
  localparam logic signed [4:0]  SUB_DOWN  = -5'sd4;

  typedef struct packed {
    logic kind;
    logic pin_a;
    logic pin_b;
  } sample_t;

  typedef struct packed {
    logic        [15:0] target_rpm;
    logic signed [15:0] pending_detents;
    logic signed [15:0] taken_detents;
  } result_t;

  typedef struct packed {
    logic signed [1:0]  direction;
    logic        [11:0] step_rpm;
    logic        [15:0] min_rpm;
    logic        [15:0] max_rpm;
  } cfg_t;

  // decoder state carried between items
  typedef struct packed {
    logic        [1:0]  last_pins;
    logic               last_known;
    logic signed [3:0]  substep_sum;
    logic signed [15:0] detent_count;
  } quad_state_t;

  // x4 step for {previous pins, current pins}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/qdsk_cfg.sv
module qdsk_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output qdsk_pkg::cfg_t         cfg
);
  import qdsk_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= 2'sd1;
      cfg.step_rpm  <= 12'd50;
      cfg.min_rpm   <= 16'd0;
      cfg.max_rpm   <= 16'hffff;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_DIRECTION: cfg.direction <= $signed(cfg_data[1:0]);
        REG_STEP_RPM:  cfg.step_rpm  <= cfg_data[11:0];
        REG_MIN_RPM:   cfg.min_rpm   <= cfg_data;
        REG_MAX_RPM:   cfg.max_rpm   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/qdsk_quad.sv
module qdsk_quad (
  input  qdsk_pkg::quad_state_t cur,
  input  logic                  kind,
  input  logic [1:0]            pins,
  input  logic signed [1:0]     direction,
  output qdsk_pkg::quad_state_t upd
);
  import qdsk_pkg::*;

  logic signed [1:0] step;
  logic signed [4:0] dir_ext;
  logic signed [4:0] sum;

  assign step    = quad_step({cur.last_pins, pins});
  assign dir_ext = 5'(direction);

  always_comb begin
    upd = cur;
    sum = 5'(cur.substep_sum);
    if (!cur.last_known) begin
      upd.last_pins  = pins;
      upd.last_known = 1'b1;
    end else if (kind == KIND_SAMPLE) begin
      if (step != 2'sd0) begin
        sum = (step > 2'sd0) ? 5'(cur.substep_sum) + dir_ext
                             : 5'(cur.substep_sum) - dir_ext;
        if (sum >= SUB_UP) begin
          if (cur.detent_count != COUNT_MAX) upd.detent_count = cur.detent_count + 16'sd1;
          upd.substep_sum = 4'sd0;
        end else if (sum <= SUB_DOWN) begin
          if (cur.detent_count != COUNT_MIN) upd.detent_count = cur.detent_count - 16'sd1;
          upd.substep_sum = 4'sd0;
        end else begin
          upd.substep_sum = sum[3:0];
        end
      end else if (pins == cur.last_pins) begin
        upd.substep_sum = 4'sd0;
      end
      upd.last_pins = pins;
    end
  end

endmodule

### rtl/qdsk_clamp.sv
module qdsk_clamp (
  input  logic [15:0]        setpoint,
  input  logic signed [15:0] taken,
  input  qdsk_pkg::cfg_t     cfg,
  output logic [15:0]        setpoint_next
);
  import qdsk_pkg::*;

  logic signed [28:0] delta;
  logic signed [29:0] sum;
  logic signed [29:0] lo;
  logic signed [29:0] hi;

  assign delta = taken * $signed({1'b0, cfg.step_rpm});
  assign sum   = $signed({14'd0, setpoint}) + 30'(delta);
  assign lo    = $signed({14'd0, cfg.min_rpm});
  assign hi    = $signed({14'd0, cfg.max_rpm});

  always_comb begin
    // a zero take leaves the setpoint as it is, even outside the limits
    if (taken == 16'sd0)  setpoint_next = setpoint;
    else if (sum < lo)    setpoint_next = cfg.min_rpm;
    else if (sum > hi)    setpoint_next = cfg.max_rpm;
    else                  setpoint_next = sum[15:0];
  end

endmodule

### rtl/quadrature_detent_setpoint_knob.sv
// Quadrature detent set-point knob.
// sample channel: each item is a pin sample (kind 0) or a take request
// (kind 1) carrying pin_a/pin_b. result channel: one item per sample item
// with the clamped target rpm, the pending detent count and the detents
// moved by a take.
// cfg channel: write-only, always ready; index 0 direction, 1 step_rpm,
// 2 min_rpm, 3 max_rpm. Write only while no item is in flight.
// An accepted item is held in the input register, then registered onto result
// and stays valid there until taken (one input register, one result register).
// Throughput: one item per cycle while result is not stalled; the decoder
// update and the multiply-add-clamp of a take fit between the two registers.
// A stalled result holds in its register; the input register still takes
// one more item, after which sample_ready follows result_ready.
// Reset: pin history unknown (first item only records the pins), substep
// and detent count zero, target rpm DEFAULT_RPM, registers at defaults.
module quadrature_detent_setpoint_knob #(
  parameter logic [15:0] DEFAULT_RPM = 16'd1500
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  qdsk_pkg::sample_t   sample,
  output logic                result_valid,
  input  logic                result_ready,
  output qdsk_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import qdsk_pkg::*;

  cfg_t        cfg;
  sample_t     held;
  logic        held_full;
  logic        advance;
  quad_state_t qstate;
  quad_state_t qstate_next;
  quad_state_t qstate_keep;
  logic [15:0] setpoint;
  logic [15:0] setpoint_next;
  logic signed [15:0] taken;

  qdsk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qdsk_quad u_quad (
    .cur       (qstate),
    .kind      (held.kind),
    .pins      ({held.pin_b, held.pin_a}),
    .direction (cfg.direction),
    .upd       (qstate_next)
  );

  assign taken = (held.kind == KIND_TAKE) ? qstate_next.detent_count : 16'sd0;

  // a take moves the whole count out
  always_comb begin
    qstate_keep = qstate_next;
    if (held.kind == KIND_TAKE) qstate_keep.detent_count = 16'sd0;
  end

  qdsk_clamp u_clamp (
    .setpoint      (setpoint),
    .taken         (taken),
    .cfg           (cfg),
    .setpoint_next (setpoint_next)
  );

  assign advance      = held_full && (!result_valid || result_ready);
  assign sample_ready = !held_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_full           <= 1'b0;
      result_valid        <= 1'b0;
      qstate.last_pins    <= 2'd0;
      qstate.last_known   <= 1'b0;
      qstate.substep_sum  <= 4'sd0;
      qstate.detent_count <= 16'sd0;
      setpoint            <= DEFAULT_RPM;
    end else begin
      if (sample_valid && sample_ready) begin
        held      <= sample;
        held_full <= 1'b1;
      end else if (advance) begin
        held_full <= 1'b0;
      end

      if (advance) begin
        qstate   <= qstate_keep;
        setpoint <= setpoint_next;
        result.target_rpm      <= setpoint_next;
        result.pending_detents <= qstate_keep.detent_count;
        result.taken_detents   <= taken;
        result_valid           <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/qdsk_checker.sv
module qdsk_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input qdsk_pkg::result_t result
);
  import qdsk_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a take leaves nothing pending; a sample moves nothing
  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.taken_detents == 16'sd0 || result.pending_detents == 16'sd0))
    else $error("taken and pending both nonzero");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // an item accepted into an empty pipe passes through held into the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && !result_valid && $past(!sample_valid || !sample_ready)
      && !$past(rst) |-> ##2 result_valid)
    else $error("result missing after accept");

endmodule

bind quadrature_detent_setpoint_knob qdsk_checker u_qdsk_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### sim/quadrature_detent_setpoint_knob_test.sv
`timescale 1ns / 1ps

module quadrature_detent_setpoint_knob_test;
  import qdsk_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               knob_in = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               knob_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  quadrature_detent_setpoint_knob u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (knob_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (knob_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // knob model state and register copies, at their reset values
  logic [1:0] k_last = 2'b00;
  bit         k_known = 1'b0;
  int         k_sub = 0;
  int         k_count = 0;
  int         k_setpoint = 1500;
  int         c_dir = 1;
  int         c_step = 50;
  int         c_min = 0;
  int         c_max = 65535;

  result_t    results_due[$];
  int         fails = 0;

  // sender / receiver pacing
  int         burst_left = 0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         rx_cycle = 0;
  int         knob_pos = 0;

  // position of a pin state along the forward gray cycle 0,2,3,1
  function automatic int gray_pos(logic [1:0] p);
    return int'({p[0], p[0] ^ p[1]});
  endfunction

  function automatic logic [1:0] pos_pins(int q);
    logic [1:0] b;
    b = q[1:0];
    return {b[1] ^ b[0], b[1]};
  endfunction

  function automatic sample_t make_item(logic kind, logic [1:0] pins);
    sample_t s;
    s.kind  = kind;
    s.pin_a = pins[0];
    s.pin_b = pins[1];
    return s;
  endfunction

  function automatic result_t predict_knob_result(sample_t s);
    logic [1:0] pins;
    int         d;
    int         taken;
    longint     sum;
    result_t    r;
    pins  = {s.pin_b, s.pin_a};
    taken = 0;
    if (!k_known) begin
      k_last  = pins;
      k_known = 1'b1;
    end else if (s.kind == KIND_SAMPLE) begin
      d = (gray_pos(pins) - gray_pos(k_last) + 4) % 4;
      if (d == 1 || d == 3) begin
        k_sub += (d == 1 ? 1 : -1) * c_dir;
        if (k_sub >= 4) begin
          if (k_count < 32767) k_count++;
          k_sub = 0;
        end else if (k_sub <= -4) begin
          if (k_count > -32768) k_count--;
          k_sub = 0;
        end
      end else if (d == 0) begin
        k_sub = 0;
      end
      // a two-bit jump leaves the sub-step sum alone
      k_last = pins;
    end
    if (s.kind == KIND_TAKE) begin
      taken   = k_count;
      k_count = 0;
      if (taken != 0) begin
        sum = longint'(k_setpoint) + longint'(taken) * longint'(c_step);
        if (sum < c_min) sum = c_min;
        else if (sum > c_max) sum = c_max;
        k_setpoint = int'(sum);
      end
    end
    r.target_rpm      = k_setpoint[15:0];
    r.pending_detents = k_count[15:0];
    r.taken_detents   = taken[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_steady) begin
      result_ready <= 1'b1;
    end else begin
      case (rx_cycle[8:7])
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= ($urandom_range(0, 3) != 0);
        2'd2: result_ready <= (rx_cycle[1:0] != 2'd0);
        default: result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // register writes, accepted items and results, all seen at the same edge
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_DIRECTION: c_dir = int'($signed(cfg_data[1:0]));
          REG_STEP_RPM:  c_step = int'(cfg_data[11:0]);
          REG_MIN_RPM:   c_min = int'(cfg_data);
          REG_MAX_RPM:   c_max = int'(cfg_data);
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) results_due.push_back(predict_knob_result(knob_in));
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          fails++;
          $error("result item with none expected");
        end else begin
          want = results_due.pop_front();
          if (knob_out.target_rpm !== want.target_rpm) begin
            fails++;
            $error("target_rpm expected %0d actual %0d",
                   want.target_rpm, knob_out.target_rpm);
          end
          if (knob_out.pending_detents !== want.pending_detents) begin
            fails++;
            $error("pending_detents expected %0d actual %0d",
                   want.pending_detents, knob_out.pending_detents);
          end
          if (knob_out.taken_detents !== want.taken_detents) begin
            fails++;
            $error("taken_detents expected %0d actual %0d",
                   want.taken_detents, knob_out.taken_detents);
          end
        end
      end
    end
  end

  task automatic send_item(sample_t s);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    sample_valid <= 1'b1;
    knob_in      <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int dir, int stp, int lo, int hi);
    write_reg(REG_DIRECTION, 16'(dir));
    write_reg(REG_STEP_RPM, 16'(stp));
    write_reg(REG_MIN_RPM, 16'(lo));
    write_reg(REG_MAX_RPM, 16'(hi));
  endtask

  // walk the knob n quarter steps, forward for n > 0
  task automatic turn(int n);
    int i;
    int steps;
    steps = (n < 0) ? -n : n;
    for (i = 0; i < steps; i++) begin
      knob_pos = (knob_pos + ((n < 0) ? 3 : 1)) % 4;
      send_item(make_item(KIND_SAMPLE, pos_pins(knob_pos)));
    end
  endtask

  task automatic take_detents(logic [1:0] pins);
    send_item(make_item(KIND_TAKE, pins));
  endtask

  task automatic test_first_take();
    knob_pos = gray_pos(2'b11);
    take_detents(2'b11);
  endtask

  task automatic test_detents_and_noise();
    turn(4);
    take_detents(2'b00);
    turn(-2);
    send_item(make_item(KIND_SAMPLE, pos_pins(knob_pos)));
    knob_pos = (knob_pos + 2) % 4;
    send_item(make_item(KIND_SAMPLE, pos_pins(knob_pos)));
    turn(-4);
    take_detents(2'b01);
    take_detents(2'b10);
  endtask

  task automatic test_register_extremes();
    set_regs(-1, 4095, 0, 65535);
    turn(4);
    take_detents(2'b11);
    write_reg(REG_DIRECTION, 16'h0000);
    turn(1);
    take_detents(2'b00);
    write_reg(REG_DIRECTION, 16'h0002);
    turn(-2);
    take_detents(2'b01);
    // inverted limits
    set_regs(-2, 1, 3000, 1000);
    turn(-2);
    take_detents(2'b10);
    turn(2);
    take_detents(2'b11);
    write_reg(REG_STEP_RPM, 16'h0000);
    turn(-2);
    take_detents(2'b00);
  endtask

  // unbroken streams with the receiver always ready
  task automatic test_steady_stream();
    set_regs(-2, 4095, 0, 65535);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    turn(-100);
    take_detents(2'b10);
    turn(100);
    take_detents(2'b01);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_phases();
    int ph;
    int n;
    int r;
    int spin;
    int lo;
    int hi;
    spin = 1;
    for (ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 3))
        0: begin lo = 0; hi = 65535; end
        1: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
        2: begin lo = $urandom_range(0, 2000); hi = $urandom_range(2000, 65535); end
        default: begin lo = $urandom_range(30000, 65535); hi = $urandom_range(0, 29999); end
      endcase
      if (ph == 0) set_regs(1, 50, 0, 65535);
      else if (ph == 1) set_regs(-1, 4095, lo, hi);
      else set_regs($urandom, ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 200),
                    lo, hi);
      for (n = 0; n < 220; n++) begin
        if (ph == 3 && n == 110) drain_results();
        r = $urandom_range(0, 99);
        if (r < 5) spin = -spin;
        if (r < 8) begin
          take_detents(2'($urandom_range(0, 3)));
        end else if (r < 88) begin
          turn(spin);
        end else if (r < 95) begin
          send_item(make_item(KIND_SAMPLE, pos_pins(knob_pos)));
        end else begin
          knob_pos = (knob_pos + 2) % 4;
          send_item(make_item(KIND_SAMPLE, pos_pins(knob_pos)));
        end
      end
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_first_take();
    test_detents_and_noise();
    test_register_extremes();
    test_steady_stream();
    test_random_phases();
    sample_valid <= 1'b0;
    @(posedge clk);
    for (guard = 0; guard < 20000 && results_due.size() != 0; guard++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (results_due.size() != 0) begin
      fails++;
      $error("%0d expected result items never arrived", results_due.size());
    end
    if (fails == 0) begin
      $display("quadrature_detent_setpoint_knob_test OK");
    end else begin
      $display("quadrature_detent_setpoint_knob_test NOT OK");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("quadrature_detent_setpoint_knob_test NOT OK");
    $finish;
  end

endmodule
